@@ rtl/pixel_intensity_histogram_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pixel intensity histogram
// Shared property shapes, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIXEL_INTENSITY_HISTOGRAM_ASSERT_SVH
`define PIXEL_INTENSITY_HISTOGRAM_ASSERT_SVH

// Condition in the same cycle implies consequence in the same cycle.
`define PIH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in one cycle implies consequence in the next cycle.
`define PIH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Expression must never be true.
`define PIH_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ rtl/pih_pkg.sv @@
// ----------------------------------------------------------------------------
// pih_pkg
// Types, constants and helpers shared by the histogram front end, the
// operation queue and the bin update engine.
// ----------------------------------------------------------------------------
package pih_pkg;

    // Bin store geometry.
    localparam int NUM_BINS    = 256;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int COUNT_WIDTH = 24;
    localparam int OUT_WIDTH   = 24;
    localparam int SAMPLE_W    = 8;

    // Operation queue between front end and update engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_COUNT    = 2'd0;
    localparam logic [1:0] CMD_READ     = 2'd1;
    localparam logic [1:0] CMD_READ_CLR = 2'd2;

    // Channel select codes.
    localparam logic [1:0] CH_0 = 2'd0;
    localparam logic [1:0] CH_1 = 2'd1;
    localparam logic [1:0] CH_2 = 2'd2;

    // Work handed to the update engine.
    typedef enum logic [1:0] {
        OP_INC,
        OP_READ,
        OP_READ_CLR
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [BIN_W-1:0] bin;
    } op_t;

    // Queue status seen by the front end and the engine.
    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

    // Update engine states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } back_state_t;

    // Saturating increment of one bin.
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH-1:0] r;
        if (c == {COUNT_WIDTH{1'b1}})
            r = c;
        else
            r = c + COUNT_WIDTH'(1);
        return r;
    endfunction

    // Low OUT_WIDTH bits of a bin, zero extended when the bin is narrower.
    function automatic logic [OUT_WIDTH-1:0] to_out(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+OUT_WIDTH-1:0] ext;
        ext = (COUNT_WIDTH+OUT_WIDTH)'(c);
        return ext[OUT_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/pixel_intensity_histogram.sv @@
// ----------------------------------------------------------------------------
// pixel_intensity_histogram
// 256-bin intensity histogram of one color channel of a pixel stream.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one item per pixel or query.
// cmd 0 counts the pixel: the sample chosen by channel_select picks the bin,
// which is incremented and saturates at its largest value. cmd 1 reads a bin
// and cmd 2 reads it and clears it; each returns one item on the output
// channel (out_valid/out_ready) with bin_number and the count before clearing.
// Other codes, and counts with channel select 3, are accepted and do nothing.
// The configuration channel (cfg_valid/cfg_ready) writes channel_select; it
// is always ready. The user must see that it is written only while the block
// is idle; the block itself does not enforce this. The engine runs one
// operation at a time as a read-modify-write of the single bin RAM: the read
// is issued in S_IDLE, the update and write follow in S_EXEC. An accepted
// read passes the queue, S_IDLE and S_EXEC before its result is registered.
// A four-entry queue lets input items be taken while the engine stalls.
// Reset: channel_select returns to 0 and a clearing pass writes zero to all
// 256 bins, one per cycle; in_ready stays low for the whole pass.
// When the receiver stalls, the pending result holds in the output register,
// the engine waits, and in_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module pixel_intensity_histogram import pih_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic [SAMPLE_W-1:0]  sample_c0,
    input  logic [SAMPLE_W-1:0]  sample_c1,
    input  logic [SAMPLE_W-1:0]  sample_c2,
    input  logic [BIN_W-1:0]     bin_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BIN_W-1:0]     bin_number,
    output logic [OUT_WIDTH-1:0] bin_count
);

    queue_status_t q_status;
    logic          push;
    op_t           push_op;
    logic          pop;
    op_t           head_op;
    logic          clearing;

    // Front end: configuration and command classification.
    pih_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .sample_c0 (sample_c0),
        .sample_c1 (sample_c1),
        .sample_c2 (sample_c2),
        .bin_index (bin_index),
        .q_status  (q_status),
        .clearing  (clearing),
        .push      (push),
        .push_op   (push_op)
    );

    // Operation queue.
    pih_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    // Bin update engine and output register.
    pih_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_op       (head_op),
        .q_pop      (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bin_number (bin_number),
        .bin_count  (bin_count)
    );

endmodule

@@ rtl/pih_ram.sv @@
// ----------------------------------------------------------------------------
// pih_ram
// Generic simple dual port RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module pih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pih_front.sv @@
// ----------------------------------------------------------------------------
// pih_front
// Holds the channel select register, accepts input items and turns each into
// a bin operation for the queue. Items that do nothing are accepted and dropped.
// ----------------------------------------------------------------------------
module pih_front import pih_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [SAMPLE_W-1:0] sample_c0,
    input  logic [SAMPLE_W-1:0] sample_c1,
    input  logic [SAMPLE_W-1:0] sample_c2,
    input  logic [BIN_W-1:0]    bin_index,
    input  queue_status_t       q_status,
    input  logic                clearing,
    output logic                push,
    output op_t                 push_op
);

    logic [1:0] channel_select_reg;
    logic       accept;
    logic       op_ok;
    logic       sample_ok;
    logic [BIN_W-1:0] sample_bin;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            channel_select_reg <= CH_0;
        else if (cfg_valid)
            channel_select_reg <= cfg_data;
    end

    // Input handshake: held off during the clearing pass or when the queue is full.
    assign in_ready = !q_status.full && !clearing;
    assign accept   = in_valid && in_ready;

    // Pick the sample of the configured channel.
    always_comb
    begin
        sample_ok  = 1'b1;
        sample_bin = sample_c0;
        case (channel_select_reg)
            CH_0: sample_bin = sample_c0;
            CH_1: sample_bin = sample_c1;
            CH_2: sample_bin = sample_c2;
            default: sample_ok = 1'b0;
        endcase
    end

    // Classify the command.
    always_comb
    begin
        op_ok        = 1'b0;
        push_op.kind = OP_INC;
        push_op.bin  = bin_index;
        case (cmd)
            CMD_COUNT:
            begin
                op_ok        = sample_ok;
                push_op.kind = OP_INC;
                push_op.bin  = sample_bin;
            end
            CMD_READ:
            begin
                op_ok        = 1'b1;
                push_op.kind = OP_READ;
            end
            CMD_READ_CLR:
            begin
                op_ok        = 1'b1;
                push_op.kind = OP_READ_CLR;
            end
            default: op_ok = 1'b0;
        endcase
    end

    assign push = accept && op_ok;

endmodule

@@ rtl/pih_queue.sv @@
// ----------------------------------------------------------------------------
// pih_queue
// Small FIFO of bin operations between the front end and the update engine.
// ----------------------------------------------------------------------------
module pih_queue import pih_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  op_t           push_op,
    input  logic          pop,
    output op_t           head_op,
    output queue_status_t status
);

`include "pixel_intensity_histogram_assert.svh"

    op_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign status.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign status.valid = (count_reg != '0);
    assign head_op      = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    // Occupancy.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QUEUE_AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QUEUE_AW+1)'(1);
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    `PIH_ASSERT_NEVER(a_q_no_overflow, push && status.full, "push into a full queue")
    `PIH_ASSERT_NEVER(a_q_no_underflow, pop && !status.valid, "pop from an empty queue")

endmodule

@@ rtl/pih_back.sv @@
// ----------------------------------------------------------------------------
// pih_back
// Bin update engine: clears the bin store after reset, then runs one queued
// operation at a time as a read-modify-write on the RAM, and holds the read
// result in an output register.
// ----------------------------------------------------------------------------
module pih_back import pih_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  queue_status_t        q_status,
    input  op_t                  q_op,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BIN_W-1:0]     bin_number,
    output logic [OUT_WIDTH-1:0] bin_count
);

`include "pixel_intensity_histogram_assert.svh"

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [BIN_W-1:0]       clr_cnt_reg;
    op_t                    op_reg;
    logic                   out_valid_reg;
    logic [BIN_W-1:0]       bin_number_reg;
    logic [OUT_WIDTH-1:0]   bin_count_reg;

    logic                   needs_out;
    logic                   go;
    logic                   out_load;
    logic                   ram_we;
    logic [BIN_W-1:0]       ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] ram_rdata;

    // Bin store.
    pih_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (q_op.bin),
        .rdata (ram_rdata)
    );

    // A read needs room in the output register before it can finish.
    assign needs_out = (op_reg.kind != OP_INC);
    assign go        = !needs_out || !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == BIN_W'(NUM_BINS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_status.valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (go)
                    state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // State outputs.
    always_comb
    begin
        clearing  = 1'b0;
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = op_reg.bin;
        ram_wdata = '0;
        out_load  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clearing  = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
            end
            S_IDLE:
            begin
                q_pop = q_status.valid;
            end
            S_EXEC:
            begin
                out_load = go && needs_out;
                ram_we   = go && (op_reg.kind != OP_READ);
                if (op_reg.kind == OP_INC)
                    ram_wdata = sat_inc(ram_rdata);
            end
            default: clearing = 1'b1;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + BIN_W'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
            op_reg <= q_op;
        if (out_load)
        begin
            bin_number_reg <= op_reg.bin;
            bin_count_reg  <= to_out(ram_rdata);
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_number = bin_number_reg;
    assign bin_count  = bin_count_reg;

    `PIH_ASSERT_SAME(a_no_pop_in_clear, state_reg == S_CLEAR, !q_pop, "queue popped while clearing")
    `PIH_ASSERT_SAME(a_no_write_in_idle, state_reg == S_IDLE, !ram_we, "bin write without an operation")
    `PIH_ASSERT_NEXT(a_pop_then_exec, q_pop, state_reg == S_EXEC, "popped operation not executed")

endmodule

@@ tb/pixel_intensity_histogram_tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for pixel_intensity_histogram
// Drives count, read and read-and-clear items through the valid/ready input
// channel and keeps a shadow copy of all 256 bins and the channel select.
// Every bin read that comes back is checked field by field, in order, against
// the shadow copy. Both channels idle at random. One phase stalls the output
// for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module pixel_intensity_histogram_tb;
    import pih_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam logic [1:0] CH_NONE  = 2'd3;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES  = 150;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [BIN_W-1:0]     bin_number;
        logic [OUT_WIDTH-1:0] bin_count;
    } bin_read_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           cmd;
    logic [SAMPLE_W-1:0]  sample_c0;
    logic [SAMPLE_W-1:0]  sample_c1;
    logic [SAMPLE_W-1:0]  sample_c2;
    logic [BIN_W-1:0]     bin_index;
    logic                 out_valid;
    logic                 out_ready;
    logic [BIN_W-1:0]     bin_number;
    logic [OUT_WIDTH-1:0] bin_count;

    // Shadow histogram and the reads still owed by the block.
    logic [COUNT_WIDTH-1:0] shadow_bins [NUM_BINS];
    logic [1:0]             shadow_channel;
    bin_read_t              pending_reads [$];

    int  cycle_count;
    int  mismatches;
    int  items_sent;
    int  reads_checked;
    int  hold_len;
    bit  send_idle_on;
    bit  recv_idle_on;

    pixel_intensity_histogram uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .sample_c0  (sample_c0),
        .sample_c1  (sample_c1),
        .sample_c2  (sample_c2),
        .bin_index  (bin_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bin_number (bin_number),
        .bin_count  (bin_count)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d reads outstanding",
                     cycle_count, pending_reads.size());
            $display("** pixel_intensity_histogram: FAILED **");
            $finish;
        end
    end

    function automatic int draw_gap(input bit idle_on);
        return idle_on ? $urandom_range(0, 7) : 0;
    endfunction

    // Apply one accepted item to the shadow histogram and queue its read.
    task automatic tally_item(input logic [1:0] c, input logic [SAMPLE_W-1:0] s0,
                              input logic [SAMPLE_W-1:0] s1,
                              input logic [SAMPLE_W-1:0] s2,
                              input logic [BIN_W-1:0] b);
        logic [SAMPLE_W-1:0] pick;
        bin_read_t           rd;
        if (c == CMD_COUNT)
        begin
            if (shadow_channel != CH_NONE)
            begin
                case (shadow_channel)
                    CH_0:    pick = s0;
                    CH_1:    pick = s1;
                    default: pick = s2;
                endcase
                if (shadow_bins[pick] != {COUNT_WIDTH{1'b1}})
                    shadow_bins[pick] = shadow_bins[pick] + 1'b1;
            end
        end
        else if (c == CMD_READ || c == CMD_READ_CLR)
        begin
            rd.bin_number = b;
            rd.bin_count  = OUT_WIDTH'(shadow_bins[b]);
            pending_reads = {pending_reads, rd};
            if (c == CMD_READ_CLR)
                shadow_bins[b] = '0;
        end
    endtask

    // Offer one item and return at the falling edge after it is taken.
    // Valid is left high so that a following item can go out with no gap.
    task automatic send_item(input logic [1:0] c, input logic [SAMPLE_W-1:0] s0,
                             input logic [SAMPLE_W-1:0] s1,
                             input logic [SAMPLE_W-1:0] s2,
                             input logic [BIN_W-1:0] b);
        int gap;
        gap = draw_gap(send_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= c;
        sample_c0 <= s0;
        sample_c1 <= s1;
        sample_c2 <= s2;
        bin_index <= b;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        tally_item(c, s0, s1, s2, b);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid at the falling edge where the last item returned.
    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    // Wait until every read has come back and the engine has gone quiet.
    task automatic wait_drain();
        while (pending_reads.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write channel_select once the block is idle.
    task automatic write_channel(input logic [1:0] ch);
        wait_drain();
        cfg_data  <= ch;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_channel = ch;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Output side: random stalls, and a long hold when a test asks for one.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(recv_idle_on);
            if (hold_len > 0)
            begin
                gap      = hold_len;
                hold_len = 0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Compare each returned item with the oldest pending read.
    always @(posedge clk)
    begin
        bin_read_t exp_rd;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result item: bin %0d count %0d",
                             bin_number, bin_count);
            end
            else
            begin
                exp_rd = pending_reads.pop_front();
                reads_checked++;
                if (bin_number !== exp_rd.bin_number || bin_count !== exp_rd.bin_count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Mismatch: expected bin %0d count %0d, got bin %0d count %0d",
                                 exp_rd.bin_number, exp_rd.bin_count, bin_number, bin_count);
                end
            end
        end
    end

    // Bins 0 and 255 read as zero right after the clearing pass.
    task automatic test_reset_state();
        send_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        end_burst();
    endtask

    // Extreme samples, each command, channel selection and the ignored cases.
    task automatic test_directed();
        write_channel(CH_0);
        send_item(CMD_COUNT, 8'd0, 8'd255, 8'd128, 8'd17);
        send_item(CMD_COUNT, 8'd255, 8'd0, 8'd1, 8'd0);
        send_item(CMD_COUNT, 8'd255, 8'd3, 8'd4, 8'd255);
        send_item(CMD_READ, 8'd9, 8'd9, 8'd9, 8'd0);
        send_item(CMD_READ, 8'd9, 8'd9, 8'd9, 8'd255);
        send_item(CMD_READ_CLR, 8'd9, 8'd9, 8'd9, 8'd255);
        send_item(CMD_READ, 8'd9, 8'd9, 8'd9, 8'd255);
        // An unused command must leave bin 0 untouched.
        send_item(CMD_NONE, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(CMD_READ, 8'd1, 8'd1, 8'd1, 8'd0);
        end_burst();

        write_channel(CH_1);
        send_item(CMD_COUNT, 8'd255, 8'd7, 8'd255, 8'd0);
        send_item(CMD_READ_CLR, 8'd0, 8'd0, 8'd0, 8'd7);
        send_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd255);
        end_burst();

        write_channel(CH_2);
        send_item(CMD_COUNT, 8'd0, 8'd0, 8'd200, 8'd0);
        send_item(CMD_COUNT, 8'd255, 8'd255, 8'd200, 8'd200);
        send_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd200);
        send_item(CMD_READ_CLR, 8'd0, 8'd0, 8'd0, 8'd200);
        end_burst();

        // With the unused channel code a count changes nothing.
        write_channel(CH_NONE);
        send_item(CMD_COUNT, 8'd5, 8'd5, 8'd5, 8'd5);
        send_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd5);
        end_burst();
    endtask

    // Random mix under one channel setting; samples cluster around a base so
    // that reads often land on bins with counts in them.
    task automatic test_random_phase(input logic [1:0] ch, input int n);
        int                  base;
        int                  r;
        logic [1:0]          c;
        logic [SAMPLE_W-1:0] s [3];
        logic [BIN_W-1:0]    b;
        write_channel(ch);
        base = $urandom_range(0, 248);
        for (int i = 0; i < n; i++)
        begin
            // The first stretch of each phase runs with no idling at all.
            send_idle_on = (i >= 30);
            recv_idle_on = (i >= 30);
            r = $urandom_range(0, 99);
            if (r < 55)
                c = CMD_COUNT;
            else if (r < 78)
                c = CMD_READ;
            else if (r < 95)
                c = CMD_READ_CLR;
            else
                c = CMD_NONE;
            for (int k = 0; k < 3; k++)
                s[k] = ($urandom_range(0, 1) == 1) ? SAMPLE_W'(base + $urandom_range(0, 7))
                                                   : SAMPLE_W'($urandom_range(0, 255));
            b = ($urandom_range(0, 9) < 6) ? BIN_W'(base + $urandom_range(0, 7))
                                           : BIN_W'($urandom_range(0, 255));
            send_item(c, s[0], s[1], s[2], b);
        end
        end_burst();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // Long output stall while the input keeps pushing back to back.
    task automatic test_back_pressure();
        logic [1:0] c;
        write_channel(CH_1);
        send_idle_on = 1'b0;
        hold_len     = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
        begin
            c = ($urandom_range(0, 3) == 0) ? CMD_COUNT : CMD_READ;
            send_item(c, SAMPLE_W'($urandom_range(0, 255)), SAMPLE_W'($urandom_range(0, 15)),
                      SAMPLE_W'($urandom_range(0, 255)), BIN_W'($urandom_range(0, 15)));
        end
        end_burst();
        // The sender waits here until every read has returned.
        wait_drain();
        send_idle_on = 1'b1;
    endtask

    // Main sequence.
    initial
    begin
        cycle_count   = 0;
        mismatches    = 0;
        items_sent    = 0;
        reads_checked = 0;
        hold_len      = 0;
        send_idle_on  = 1'b1;
        recv_idle_on  = 1'b1;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        cmd           = CMD_COUNT;
        sample_c0     = '0;
        sample_c1     = '0;
        sample_c2     = '0;
        bin_index     = '0;
        shadow_channel = CH_0;
        for (int i = 0; i < NUM_BINS; i++)
            shadow_bins[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_directed();
        test_random_phase(CH_0, 140);
        test_random_phase(CH_1, 140);
        test_random_phase(CH_2, 140);
        test_random_phase(CH_NONE, 100);
        test_back_pressure();
        test_random_phase(CH_2, 140);
        test_random_phase(CH_0, 60);

        wait_drain();
        $display("Sent %0d items and checked %0d bin reads across channel settings 0 to 3,",
                 items_sent, reads_checked);
        $display("with random idling on both sides and a %0d-cycle output stall; %0d mismatches.",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("** pixel_intensity_histogram: PASSED **");
        else
            $display("** pixel_intensity_histogram: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pih_pkg.sv
rtl/pih_ram.sv
rtl/pih_front.sv
rtl/pih_queue.sv
rtl/pih_back.sv
rtl/pixel_intensity_histogram.sv
tb/pixel_intensity_histogram_tb.sv
